// ===== sv/melody_to_motor_sequencer_macros.svh =====
// assertion helpers shared by the checker
`ifndef MELODY_TO_MOTOR_SEQUENCER_MACROS_SVH
`define MELODY_TO_MOTOR_SEQUENCER_MACROS_SVH

// same-cycle implication, off while reset is low
`define MTS_ASSERT_IMP(lbl, c, r, a, b, msg) \
  lbl: assert property (@(posedge c) disable iff (!r) (a) |-> (b)) else $error(msg);

// next-cycle implication, off while reset is low
`define MTS_ASSERT_NXT(lbl, c, r, a, b, msg) \
  lbl: assert property (@(posedge c) disable iff (!r) (a) |=> (b)) else $error(msg);

// next-cycle implication that also holds through reset
`define MTS_ASSERT_ALWAYS(lbl, c, a, b, msg) \
  lbl: assert property (@(posedge c) (a) |=> (b)) else $error(msg);

`endif

// ===== sv/mts_pkg.sv =====
`default_nettype none
package mts_pkg;

  localparam int PITCH_W = 13;
  localparam int LEN_W   = 8;
  localparam int WHOLE_W = 18;
  localparam int DUR_W   = 19;
  localparam int COUNT_W = 7;
  localparam int CFG_IW  = 3;
  localparam int CFG_DW  = 18;

  // shared divider widths
  localparam int DIV_NW = 19;
  localparam int DIV_DW = 13;
  localparam int DIV_CW = $clog2(DIV_NW);

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_STOP  = 2'd1;
  localparam logic [1:0] CMD_DRIVE = 2'd2;

  localparam logic [CFG_IW-1:0] REG_NOTE_COUNT = 3'd0;
  localparam logic [CFG_IW-1:0] REG_WHOLE_NOTE = 3'd1;
  localparam logic [CFG_IW-1:0] REG_PITCH_MIN  = 3'd2;
  localparam logic [CFG_IW-1:0] REG_PITCH_MAX  = 3'd3;
  localparam logic [CFG_IW-1:0] REG_REST_PITCH = 3'd4;

  localparam logic [COUNT_W-1:0] RST_NOTE_COUNT = 7'd0;
  localparam logic [WHOLE_W-1:0] RST_WHOLE_NOTE = 18'd2000;
  localparam logic [PITCH_W-1:0] RST_PITCH_MIN  = 13'd31;
  localparam logic [PITCH_W-1:0] RST_PITCH_MAX  = 13'd4978;
  localparam logic [PITCH_W-1:0] RST_REST_PITCH = 13'd0;

  localparam logic [5:0] SPEED_LO   = 6'd25;
  localparam logic [5:0] SPEED_HI   = 6'd63;
  localparam logic [5:0] SPEED_SPAN = 6'd38;
  localparam logic [7:0] CTRL_FWD   = 8'h02;

  typedef struct packed {
    logic [1:0]             opcode;
    logic [5:0]             note_slot;
    logic [PITCH_W-1:0]     note_pitch;
    logic signed [LEN_W-1:0] note_length;
    logic                   restart_override;
  } in_word_t;

  typedef struct packed {
    logic [1:0] motor_cmd;
    logic [7:0] motor_control;
    logic       playing;
  } out_word_t;

  typedef struct packed {
    logic [PITCH_W-1:0]      pitch;
    logic signed [LEN_W-1:0] length;
  } note_entry_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

// ===== sv/mts_ram.sv =====
`default_nettype none
module mts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== sv/mts_div.sv =====
`default_nettype none
module mts_div (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire mts_pkg::div_req_t req,
  output mts_pkg::div_rsp_t   rsp
);
  import mts_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DIV_CW-1:0] cnt_r, cnt_nxt;
  logic [DIV_DW:0]   rem_r, rem_nxt;
  logic [DIV_NW-1:0] quo_r, quo_nxt;
  logic [DIV_DW-1:0] dvs_r, dvs_nxt;
  logic [DIV_DW:0]   trial;
  logic              ge;

  // restoring division, one quotient bit per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    trial    = {rem_r[DIV_DW-1:0], quo_r[DIV_NW-1]};
    ge       = trial >= {1'b0, dvs_r};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CW'(DIV_NW - 1);
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? trial - {1'b0, dvs_r} : trial;
      quo_nxt = {quo_r[DIV_NW-2:0], ge};
      cnt_nxt = cnt_r - DIV_CW'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule
`default_nettype wire

// ===== sv/melody_to_motor_sequencer.sv =====
// melody_to_motor_sequencer: plays a note table as motor drive/stop writes
//
// input channel (in_valid/in_ready/in_word): load, start and 1 ms tick
// words. Every accepted word gives exactly one result word on the output
// channel (out_valid/out_ready/out_word), in order.
// config port (cfg_we/cfg_index/cfg_wdata): register writes, taken at any
// edge with cfg_we high, meant only while the block is idle.
// one word is processed at a time. Load, start, idle or counting ticks pass
// from acceptance through S_PUSH into the result register. A tick whose
// countdown expires reads the note table, runs the shared one bit per cycle
// divider for the note duration (unless the length is zero) and, for a
// sounding note with pmax above pmin, again for the pitch to speed mapping.
// a finished result sits in an output register; the next word is accepted
// while it waits for out_ready, and its own result holds until the output
// register frees up.
// reset: configuration returns to defaults, playback stops, the output is
// empty. The note table keeps whatever it held and needs no clearing.
`default_nettype none
module melody_to_motor_sequencer #(
  parameter int MAX_NOTES = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire mts_pkg::in_word_t             in_word,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output mts_pkg::out_word_t                 out_word,
  input  wire logic                          cfg_we,
  input  wire logic [mts_pkg::CFG_IW-1:0]    cfg_index,
  input  wire logic [mts_pkg::CFG_DW-1:0]    cfg_wdata
);
  import mts_pkg::*;

  localparam int AW = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
  localparam int PW = $clog2(MAX_NOTES + 1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_FETCH   = 3'd1;
  localparam logic [2:0] S_DIV_DUR = 3'd2;
  localparam logic [2:0] S_NOTE    = 3'd3;
  localparam logic [2:0] S_DIV_SPD = 3'd4;
  localparam logic [2:0] S_PUSH    = 3'd5;

  logic [COUNT_W-1:0] count_r;
  logic [WHOLE_W-1:0] whole_r;
  logic [PITCH_W-1:0] pmin_r, pmax_r, rest_r;

  logic [2:0]       state_r, state_nxt;
  logic [PW-1:0]    pos_r, pos_nxt;
  logic [DUR_W-1:0] wait_r, wait_nxt;
  logic [DUR_W-1:0] dur_r, dur_nxt;
  logic             pause_r, pause_nxt;
  logic             playing_r, playing_nxt;
  logic [1:0]       res_cmd_r, res_cmd_nxt;
  logic [7:0]       res_ctrl_r, res_ctrl_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_word_r, out_word_nxt;

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  note_entry_t       mem_wdata, ent;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  logic [31:0]        slot_ext, count_eff;
  logic               slot_ok, at_end;
  logic [DUR_W-1:0]   wait_dec;
  logic [LEN_W-1:0]   len_mag;
  logic [PITCH_W-1:0] pitch_c, pitch_off, pitch_span;
  logic [DIV_NW-1:0]  spd_num;
  logic [5:0]         speed;

  mts_ram #(
    .WIDTH ($bits(note_entry_t)),
    .DEPTH (MAX_NOTES)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (ent)
  );

  mts_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= RST_NOTE_COUNT;
      whole_r <= RST_WHOLE_NOTE;
      pmin_r  <= RST_PITCH_MIN;
      pmax_r  <= RST_PITCH_MAX;
      rest_r  <= RST_REST_PITCH;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NOTE_COUNT: count_r <= cfg_wdata[COUNT_W-1:0];
        REG_WHOLE_NOTE: whole_r <= cfg_wdata[WHOLE_W-1:0];
        REG_PITCH_MIN:  pmin_r  <= cfg_wdata[PITCH_W-1:0];
        REG_PITCH_MAX:  pmax_r  <= cfg_wdata[PITCH_W-1:0];
        REG_REST_PITCH: rest_r  <= cfg_wdata[PITCH_W-1:0];
        default: ;
      endcase
    end
  end

  assign slot_ext  = 32'(in_word.note_slot);
  assign slot_ok   = slot_ext < MAX_NOTES;
  assign mem_waddr = slot_ext[AW-1:0];
  assign mem_wdata = '{pitch: in_word.note_pitch, length: in_word.note_length};
  assign mem_raddr = pos_r[AW-1:0];

  assign count_eff = (32'(count_r) > MAX_NOTES) ? MAX_NOTES : 32'(count_r);
  assign at_end    = 32'(pos_r) >= count_eff;
  assign wait_dec  = (wait_r != '0) ? wait_r - DUR_W'(1) : wait_r;

  // dotted lengths divide by the magnitude
  assign len_mag    = ent.length[LEN_W-1] ? (~ent.length + LEN_W'(1)) : ent.length;
  assign pitch_c    = (ent.pitch < pmin_r) ? pmin_r :
                      (ent.pitch > pmax_r) ? pmax_r : ent.pitch;
  assign pitch_off  = pitch_c - pmin_r;
  assign pitch_span = pmax_r - pmin_r;
  assign spd_num    = DIV_NW'(pitch_off) * DIV_NW'(SPEED_SPAN);
  assign speed      = div_rsp.quotient[5:0] + SPEED_LO;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    wait_nxt      = wait_r;
    dur_nxt       = dur_r;
    pause_nxt     = pause_r;
    playing_nxt   = playing_r;
    res_cmd_nxt   = res_cmd_r;
    res_ctrl_nxt  = res_ctrl_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_word_nxt  = out_word_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    div_req       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt    = S_PUSH;
          res_cmd_nxt  = CMD_NONE;
          res_ctrl_nxt = '0;
          case (in_word.opcode)
            OP_LOAD: mem_we = slot_ok;
            OP_START: begin
              if (!playing_r || in_word.restart_override) begin
                pos_nxt     = '0;
                dur_nxt     = '0;
                wait_nxt    = '0;
                pause_nxt   = 1'b0;
                playing_nxt = 1'b1;
              end
            end
            OP_TICK: begin
              if (!playing_r) begin
                res_cmd_nxt = CMD_STOP;
              end else if (at_end) begin
                pos_nxt     = '0;
                playing_nxt = 1'b0;
                res_cmd_nxt = CMD_STOP;
              end else begin
                wait_nxt = wait_dec;
                if (wait_dec == '0) begin
                  mem_re    = 1'b1;
                  state_nxt = S_FETCH;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_FETCH: begin
        // zero length keeps the previous duration
        if (ent.length != '0) begin
          div_req.start    = 1'b1;
          div_req.dividend = DIV_NW'(whole_r);
          div_req.divisor  = DIV_DW'(len_mag);
          state_nxt        = S_DIV_DUR;
        end else begin
          state_nxt = S_NOTE;
        end
      end
      S_DIV_DUR: begin
        if (div_rsp.done) begin
          dur_nxt   = ent.length[LEN_W-1] ?
                      div_rsp.quotient + (div_rsp.quotient >> 1) : div_rsp.quotient;
          state_nxt = S_NOTE;
        end
      end
      S_NOTE: begin
        wait_nxt = dur_r >> 1;
        if (pause_r) begin
          res_cmd_nxt  = CMD_STOP;
          res_ctrl_nxt = '0;
          pause_nxt    = 1'b0;
          pos_nxt      = pos_r + PW'(1);
          state_nxt    = S_PUSH;
        end else begin
          pause_nxt = 1'b1;
          if (ent.pitch == rest_r) begin
            res_cmd_nxt  = CMD_NONE;
            res_ctrl_nxt = '0;
            state_nxt    = S_PUSH;
          end else if (pmax_r <= pmin_r) begin
            res_cmd_nxt  = CMD_DRIVE;
            res_ctrl_nxt = {SPEED_LO, 2'b00} | CTRL_FWD;
            state_nxt    = S_PUSH;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = spd_num;
            div_req.divisor  = pitch_span;
            state_nxt        = S_DIV_SPD;
          end
        end
      end
      S_DIV_SPD: begin
        if (div_rsp.done) begin
          res_cmd_nxt  = CMD_DRIVE;
          res_ctrl_nxt = {speed, 2'b00} | CTRL_FWD;
          state_nxt    = S_PUSH;
        end
      end
      S_PUSH: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = '{motor_cmd: res_cmd_r, motor_control: res_ctrl_r,
                            playing: playing_r};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      wait_r      <= '0;
      dur_r       <= '0;
      pause_r     <= 1'b0;
      playing_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      wait_r      <= wait_nxt;
      dur_r       <= dur_nxt;
      pause_r     <= pause_nxt;
      playing_r   <= playing_nxt;
      out_valid_r <= out_valid_nxt;
    end
    res_cmd_r  <= res_cmd_nxt;
    res_ctrl_r <= res_ctrl_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
`default_nettype wire

// ===== sv/mts_chk.sv =====
`default_nettype none
`include "melody_to_motor_sequencer_macros.svh"
module mts_chk (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire mts_pkg::out_word_t out_word
);
  import mts_pkg::*;

  `MTS_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_word), "stalled result word changed or dropped")
  `MTS_ASSERT_ALWAYS(a_rst_empty, clk, !rst_n, !out_valid, "result present right after reset")
  `MTS_ASSERT_NXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready, "second word taken while one is in work")
  `MTS_ASSERT_IMP(a_drive_byte, clk, rst_n, out_valid && out_word.motor_cmd == CMD_DRIVE, out_word.motor_control[1:0] == CTRL_FWD[1:0] && out_word.motor_control[7:2] >= SPEED_LO && out_word.motor_control[7:2] <= SPEED_HI, "drive byte out of range")
  `MTS_ASSERT_IMP(a_quiet_byte, clk, rst_n, out_valid && out_word.motor_cmd != CMD_DRIVE, out_word.motor_control == '0, "control byte set without drive")

endmodule

bind melody_to_motor_sequencer mts_chk u_mts_chk (.*);
`default_nettype wire

// ===== test/motor_cmd_checker.sv =====
module motor_cmd_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  mts_pkg::in_word_t          in_word,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  mts_pkg::out_word_t         out_word,
  input  logic                       cfg_we,
  input  logic [mts_pkg::CFG_IW-1:0] cfg_index,
  input  logic [mts_pkg::CFG_DW-1:0] cfg_wdata,
  output int                         fail_count,
  output int                         pending
);
  import mts_pkg::*;

  localparam int TABLE_DEPTH = 64;

  logic [PITCH_W-1:0]      tbl_pitch [TABLE_DEPTH];
  logic signed [LEN_W-1:0] tbl_len   [TABLE_DEPTH];
  int unsigned             play_pos;
  int unsigned             countdown;
  int unsigned             note_dur;
  bit                      gap_next;
  bit                      running;

  logic [COUNT_W-1:0] note_total;
  logic [WHOLE_W-1:0] whole_ms;
  logic [PITCH_W-1:0] lo_pitch;
  logic [PITCH_W-1:0] hi_pitch;
  logic [PITCH_W-1:0] rest_code;

  out_word_t due_q [$];
  out_word_t want;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report_mismatch(string what, int got, int exp_val);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, exp_val);
    fail_count++;
  endtask

  function automatic logic [5:0] speed_for_pitch(logic [PITCH_W-1:0] p);
    int unsigned q;
    int unsigned lo;
    int unsigned hi;
    lo = lo_pitch;
    hi = hi_pitch;
    q  = p;
    if (hi <= lo) return SPEED_LO;
    if (q < lo) q = lo;
    if (q > hi) q = hi;
    return 6'((q - lo) * SPEED_SPAN / (hi - lo) + SPEED_LO);
  endfunction

  // countdown expired: either sound the current note or close it with a pause
  function automatic out_word_t fire_note();
    out_word_t   r;
    int unsigned slot;
    int unsigned whole;
    int unsigned base;
    int          len;
    r     = '0;
    slot  = (play_pos >= TABLE_DEPTH) ? TABLE_DEPTH - 1 : play_pos;
    len   = tbl_len[slot];
    whole = whole_ms;
    if (len > 0) begin
      note_dur = whole / unsigned'(len);
    end else if (len < 0) begin
      // dotted note, one and a half times as long
      base     = whole / unsigned'(-len);
      note_dur = base + (base >> 1);
    end
    note_dur  = note_dur & 32'h7FFFF;
    countdown = note_dur >> 1;
    if (gap_next) begin
      r.motor_cmd = CMD_STOP;
      gap_next    = 1'b0;
      play_pos++;
    end else begin
      if (tbl_pitch[slot] != rest_code) begin
        r.motor_cmd     = CMD_DRIVE;
        r.motor_control = {speed_for_pitch(tbl_pitch[slot]), 2'b00} | CTRL_FWD;
      end
      gap_next = 1'b1;
    end
    return r;
  endfunction

  function automatic out_word_t predict_word(in_word_t w);
    out_word_t   r;
    int unsigned limit;
    r = '0;
    case (w.opcode)
      OP_LOAD: begin
        tbl_pitch[w.note_slot] = w.note_pitch;
        tbl_len[w.note_slot]   = w.note_length;
      end
      OP_START: begin
        if (!running || w.restart_override) begin
          play_pos  = 0;
          note_dur  = 0;
          countdown = 0;
          gap_next  = 1'b0;
          running   = 1'b1;
        end
      end
      OP_TICK: begin
        if (!running) begin
          r.motor_cmd = CMD_STOP;
        end else begin
          limit = (note_total > TABLE_DEPTH) ? TABLE_DEPTH : note_total;
          if (play_pos >= limit) begin
            play_pos    = 0;
            running     = 1'b0;
            r.motor_cmd = CMD_STOP;
          end else begin
            if (countdown != 0) countdown--;
            if (countdown == 0) r = fire_note();
          end
        end
      end
      default: ;
    endcase
    r.playing = running;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      play_pos   = 0;
      countdown  = 0;
      note_dur   = 0;
      gap_next   = 1'b0;
      running    = 1'b0;
      note_total = RST_NOTE_COUNT;
      whole_ms   = RST_WHOLE_NOTE;
      lo_pitch   = RST_PITCH_MIN;
      hi_pitch   = RST_PITCH_MAX;
      rest_code  = RST_REST_PITCH;
      due_q.delete();
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_NOTE_COUNT: note_total = cfg_wdata[COUNT_W-1:0];
          REG_WHOLE_NOTE: whole_ms   = cfg_wdata[WHOLE_W-1:0];
          REG_PITCH_MIN:  lo_pitch   = cfg_wdata[PITCH_W-1:0];
          REG_PITCH_MAX:  hi_pitch   = cfg_wdata[PITCH_W-1:0];
          REG_REST_PITCH: rest_code  = cfg_wdata[PITCH_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) due_q.push_back(predict_word(in_word));
      if (out_valid && out_ready) begin
        if (due_q.size() == 0) begin
          report_mismatch("result word with none expected", out_word, 0);
        end else begin
          want = due_q.pop_front();
          if (out_word.motor_cmd != want.motor_cmd)
            report_mismatch("motor_cmd", out_word.motor_cmd, want.motor_cmd);
          if (out_word.motor_control != want.motor_control)
            report_mismatch("motor_control", out_word.motor_control, want.motor_control);
          if (out_word.playing != want.playing)
            report_mismatch("playing", out_word.playing, want.playing);
        end
      end
      pending <= due_q.size();
    end
  end

endmodule

// ===== test/tb_top.sv =====
module tb_top;
  import mts_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int PHASES          = 21;
  localparam int WORDS_PER_PHASE = 95;
  localparam int HOLD_CYCLES     = 400;
  localparam int DRAIN_CYCLES    = 60;
  localparam int TABLE_DEPTH     = 64;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  in_word_t            in_word   = '0;
  logic                in_ready;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_word_t           out_word;
  logic                cfg_we    = 1'b0;
  logic [CFG_IW-1:0]   cfg_index = '0;
  logic [CFG_DW-1:0]   cfg_wdata = '0;

  int fail_count;
  int pending;
  int tx_idle_pct = 22;
  int rx_idle_pct = 50;
  bit hold_req    = 1'b0;
  bit hold_seen   = 1'b0;
  int hold_left   = 0;

  int cur_count;
  int cur_pmin;
  int cur_pmax;
  int cur_rest;
  int pick;

  always #5 clk = ~clk;

  melody_to_motor_sequencer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  motor_cmd_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_word   (out_word),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // result side: random backpressure plus one long hold on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin
    #20000000;
    $display("FAILURE");
    $finish;
  end

  function automatic in_word_t word_of(logic [1:0] op, int slot, int pitch, int len, bit ovr);
    in_word_t w;
    w.opcode           = op;
    w.note_slot        = 6'(slot);
    w.note_pitch       = PITCH_W'(pitch);
    w.note_length      = LEN_W'(len);
    w.restart_override = ovr;
    return w;
  endfunction

  function automatic in_word_t any_word(logic [1:0] op);
    return word_of(op, $urandom_range(63), $urandom_range(8191),
                   int'($urandom_range(128)) - 64, 1'($urandom_range(1)));
  endfunction

  // load word biased toward the notes the current melody plays
  function automatic in_word_t note_word();
    in_word_t w;
    int       top;
    w   = any_word(OP_LOAD);
    top = (cur_count > TABLE_DEPTH) ? TABLE_DEPTH : cur_count;
    if (top > 0 && $urandom_range(3) != 0) w.note_slot = 6'($urandom_range(top - 1));
    case ($urandom_range(3))
      0: w.note_pitch = PITCH_W'(cur_rest);
      1: w.note_pitch = PITCH_W'($urandom_range(cur_pmin, cur_pmax));
      default: ;
    endcase
    if ($urandom_range(1)) w.note_length = LEN_W'(int'($urandom_range(8)) - 4);
    return w;
  endfunction

  task automatic send_word(in_word_t w);
    in_word  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DW'(val);
    @(posedge clk);
  endtask

  task automatic apply_setting(int cnt, int whole, int pmin, int pmax, int rest);
    write_reg(REG_NOTE_COUNT, cnt);
    write_reg(REG_WHOLE_NOTE, whole);
    write_reg(REG_PITCH_MIN, pmin);
    write_reg(REG_PITCH_MAX, pmax);
    write_reg(REG_REST_PITCH, rest);
    cfg_we    <= 1'b0;
    cur_count = cnt;
    cur_pmin  = pmin;
    cur_pmax  = pmax;
    cur_rest  = rest;
  endtask

  initial begin
    cur_count = RST_NOTE_COUNT;
    cur_pmin  = RST_PITCH_MIN;
    cur_pmax  = RST_PITCH_MAX;
    cur_rest  = RST_REST_PITCH;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // idle tick, unused opcode, start on an empty melody, then table loads
    send_word(word_of(OP_TICK, 0, 0, 0, 1'b0));
    send_word(word_of(OP_UNUSED, 63, 8191, -64, 1'b1));
    send_word(word_of(OP_START, 0, 0, 0, 1'b0));
    send_word(word_of(OP_START, 63, 8191, 64, 1'b0));
    send_word(word_of(OP_TICK, 0, 0, 0, 1'b0));
    send_word(word_of(OP_LOAD, 0, 8191, 64, 1'b0));
    send_word(word_of(OP_LOAD, 1, 0, 0, 1'b0));
    send_word(word_of(OP_LOAD, 2, 30, -1, 1'b0));
    send_word(word_of(OP_LOAD, 3, 4978, -64, 1'b0));
    send_word(word_of(OP_LOAD, 63, 0, 1, 1'b1));
    wait_idle();
    apply_setting(4, 2, RST_PITCH_MIN, RST_PITCH_MAX, RST_REST_PITCH);
    // clamped high, rest, clamped low dotted, short dotted, then end of melody
    send_word(word_of(OP_START, 0, 0, 0, 1'b0));
    repeat (9) send_word(word_of(OP_TICK, 0, 0, 0, 1'b0));
    send_word(word_of(OP_START, 0, 0, 0, 1'b0));
    send_word(word_of(OP_TICK, 0, 0, 0, 1'b0));
    send_word(word_of(OP_START, 0, 0, 0, 1'b1));
    send_word(word_of(OP_START, 0, 0, 0, 1'b0));
    send_word(word_of(OP_TICK, 0, 0, 0, 1'b0));

    // fill the whole table so that any note count reads written entries
    for (int s = 0; s < TABLE_DEPTH; s++) begin
      send_word(word_of(OP_LOAD, s, $urandom_range(8191), int'($urandom_range(128)) - 64,
                        1'($urandom_range(1))));
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      if (ph == PHASES / 3) begin
        tx_idle_pct = 50;
        rx_idle_pct <= 22;
      end
      if (ph == 2 * PHASES / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
      end
      case (ph)
        0: apply_setting(TABLE_DEPTH, 262143, 0, 8191, 0);
        1: apply_setting(127, 0, 8191, 0, 8191);
        2: apply_setting(0, RST_WHOLE_NOTE, RST_PITCH_MIN, RST_PITCH_MAX, RST_REST_PITCH);
        3: apply_setting(3, 10, 500, 500, 1);
        default: begin
          cur_pmin = $urandom_range(6000);
          if ($urandom_range(9) == 0) cur_pmax = $urandom_range(cur_pmin);
          else cur_pmax = $urandom_range(cur_pmin + 1, 8191);
          pick = $urandom_range(19);
          apply_setting(($urandom_range(9) == 0) ? TABLE_DEPTH : $urandom_range(1, 6),
                        (pick < 2) ? 0 : (pick == 2) ? 262143 : $urandom_range(1, 40),
                        cur_pmin, cur_pmax,
                        $urandom_range(1) ? 0 : $urandom_range(8191));
        end
      endcase
      // receiver stalls for a long stretch while words keep coming
      if (ph == 2 * PHASES / 3) hold_req <= ~hold_req;

      for (int k = 0; k < cur_count && k < 6; k++) begin
        in_word_t w;
        w = note_word();
        w.note_slot = 6'(k);
        send_word(w);
      end
      send_word(word_of(OP_START, 0, 0, 0, 1'b1));

      repeat (WORDS_PER_PHASE) begin
        pick = $urandom_range(99);
        if (pick < 62) send_word(any_word(OP_TICK));
        else if (pick < 74) send_word(note_word());
        else if (pick < 90) send_word(any_word(OP_START));
        else if (pick < 95) send_word(any_word(OP_UNUSED));
        else send_word(any_word(OP_TICK));
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/mts_pkg.sv
sv/mts_ram.sv
sv/mts_div.sv
sv/melody_to_motor_sequencer.sv
sv/mts_chk.sv
test/motor_cmd_checker.sv
test/tb_top.sv
